// ===== sv/lwts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwts_pkg: shared types for the longest-wait task scheduler
// Request and status codes, controller states, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lwts_pkg;

  localparam int DEF_TASK_SLOTS = 16;
  localparam int DEF_TIME_BITS  = 32;
  localparam int SLOT_FIELD_W   = 4;
  localparam int REQ_W          = 3;
  localparam int STATUS_W       = 2;
  localparam logic [7:0] BLOCK_MAX = 8'hFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK      = 3'd0,
    REQ_CREATE    = 3'd1,
    REQ_DELETE    = 3'd2,
    REQ_SET_READY = 3'd3,
    REQ_YIELD     = 3'd4,
    REQ_BLOCK     = 3'd5,
    REQ_UNBLOCK   = 3'd6
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK        = 2'd0,
    RS_BAD_SLOT  = 2'd1,
    RS_NO_SWITCH = 2'd2,
    RS_BLOCKED   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CRT_LINK,
    S_CRT_HEAD,
    S_UNL_WR,
    S_WALK,
    S_WALK_END,
    S_SELECT,
    S_STAMP,
    S_FINISH
  } state_t;

  // ring_next read source
  typedef enum logic [1:0] {NRD_NONE, NRD_KERNEL, NRD_CUR, NRD_FOLLOW} nrd_t;
  // unlink target, also issues the ring reads for it
  typedef enum logic [1:0] {UNL_NONE, UNL_SLOT, UNL_CUR} unl_t;
  typedef enum logic [1:0] {RW_NONE, RW_CRT_LINK, RW_CRT_HEAD, RW_UNLINK} ring_wr_t;
  typedef enum logic [1:0] {SW_NONE, SW_KERNEL, SW_SLOT, SW_BEST} stamp_wr_t;
  typedef enum logic [2:0] {FL_NONE, FL_CREATE, FL_SET_READY, FL_PEND, FL_FREE} flag_op_t;
  typedef enum logic [1:0] {CN_NONE, CN_TICK, CN_BLOCK, CN_UNBLOCK} cnt_op_t;
  typedef enum logic [1:0] {CUR_NONE, CUR_KERNEL, CUR_BEST} cur_op_t;

  typedef struct packed {
    logic      take;
    nrd_t      nrd;
    unl_t      unl;
    ring_wr_t  ring_wr;
    stamp_wr_t stamp_wr;
    flag_op_t  flag_op;
    cnt_op_t   cnt_op;
    cur_op_t   cur_op;
    logic      walk_init;
    logic      walk_cmp;
    logic      status_wr;
    status_t   status;
    logic      sw_set;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    req_t req;
    logic create_ok;
    logic delete_ok;
    logic del_is_cur;
    logic set_ready_ok;
    logic blocked;
    logic cur_valid;
    logic kernel_ready;
    logic walk_hit;
    logic best_is_cur;
    logic cur_pend;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/lwts_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwts_in_if: request channel
// Valid/ready channel that carries one scheduler request word.
// ----------------------------------------------------------------------------
interface lwts_in_if import lwts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [SLOT_FIELD_W-1:0] task_slot;
  logic                    ready_value;

  modport source (output valid, req_type, task_slot, ready_value, input ready);
  modport sink   (input valid, req_type, task_slot, ready_value, output ready);
endinterface
`default_nettype wire

// ===== sv/lwts_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwts_out_if: result channel
// Valid/ready channel that carries one scheduler result word.
// ----------------------------------------------------------------------------
interface lwts_out_if import lwts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    switched;
  logic [SLOT_FIELD_W-1:0] selected_slot;
  logic [STATUS_W-1:0]     status;
  logic                    ready_out;

  modport source (output valid, switched, selected_slot, status, ready_out, input ready);
  modport sink   (input valid, switched, selected_slot, status, ready_out, output ready);
endinterface
`default_nettype wire

// ===== sv/lwts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwts_ctrl: scheduler sequencer
// Steps each request through its datapath operations and the ring walk.
// ----------------------------------------------------------------------------
module lwts_ctrl import lwts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (stat.in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (stat.req)
          REQ_CREATE: state_nxt = stat.create_ok ? S_CRT_LINK : S_FINISH;
          REQ_DELETE: state_nxt = (stat.delete_ok && !stat.del_is_cur) ? S_UNL_WR : S_FINISH;
          REQ_YIELD:  state_nxt = (!stat.blocked && stat.cur_valid) ? S_WALK : S_FINISH;
          default:    state_nxt = S_FINISH;
        endcase
      end
      S_CRT_LINK: state_nxt = S_CRT_HEAD;
      S_CRT_HEAD: state_nxt = S_FINISH;
      S_UNL_WR:   state_nxt = (stat.req == REQ_YIELD) ? S_STAMP : S_FINISH;
      S_WALK: begin
        if (stat.walk_hit) state_nxt = S_WALK_END;
      end
      S_WALK_END: state_nxt = S_SELECT;
      S_SELECT: begin
        if (stat.best_is_cur)   state_nxt = S_FINISH;
        else if (stat.cur_pend) state_nxt = S_UNL_WR;
        else                    state_nxt = S_STAMP;
      end
      S_STAMP: state_nxt = S_FINISH;
      S_FINISH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.take = 1'b1;
      S_EXEC: begin
        case (stat.req)
          REQ_TICK:    cmd.cnt_op = CN_TICK;
          REQ_BLOCK:   cmd.cnt_op = CN_BLOCK;
          REQ_UNBLOCK: cmd.cnt_op = CN_UNBLOCK;
          REQ_CREATE: begin
            if (stat.create_ok) begin
              cmd.nrd = NRD_KERNEL;
            end else begin
              cmd.status_wr = 1'b1;
              cmd.status    = RS_BAD_SLOT;
            end
          end
          REQ_DELETE: begin
            if (!stat.delete_ok) begin
              cmd.status_wr = 1'b1;
              cmd.status    = RS_BAD_SLOT;
            end else if (stat.del_is_cur) begin
              cmd.flag_op = FL_PEND;
            end else begin
              cmd.unl = UNL_SLOT;
            end
          end
          REQ_SET_READY: begin
            if (stat.set_ready_ok) begin
              cmd.flag_op = FL_SET_READY;
            end else begin
              cmd.status_wr = 1'b1;
              cmd.status    = RS_BAD_SLOT;
            end
          end
          REQ_YIELD: begin
            if (stat.blocked) begin
              cmd.status_wr = 1'b1;
              cmd.status    = RS_BLOCKED;
            end else if (!stat.cur_valid) begin
              if (stat.kernel_ready) begin
                cmd.stamp_wr = SW_KERNEL;
                cmd.cur_op   = CUR_KERNEL;
                cmd.sw_set   = 1'b1;
              end else begin
                cmd.status_wr = 1'b1;
                cmd.status    = RS_NO_SWITCH;
              end
            end else begin
              cmd.nrd       = NRD_CUR;
              cmd.walk_init = 1'b1;
            end
          end
          default: cmd.take = 1'b0;
        endcase
      end
      S_CRT_LINK: begin
        cmd.ring_wr  = RW_CRT_LINK;
        cmd.stamp_wr = SW_SLOT;
        cmd.flag_op  = FL_CREATE;
      end
      S_CRT_HEAD: cmd.ring_wr = RW_CRT_HEAD;
      S_UNL_WR: begin
        cmd.ring_wr = RW_UNLINK;
        cmd.flag_op = FL_FREE;
      end
      S_WALK: begin
        cmd.walk_cmp = 1'b1;
        if (!stat.walk_hit) cmd.nrd = NRD_FOLLOW;
      end
      S_WALK_END: cmd.walk_cmp = 1'b1;
      S_SELECT: begin
        if (stat.best_is_cur) begin
          cmd.status_wr = 1'b1;
          cmd.status    = RS_NO_SWITCH;
        end else if (stat.cur_pend) begin
          cmd.unl = UNL_CUR;
        end
      end
      S_STAMP: begin
        cmd.stamp_wr = SW_BEST;
        cmd.cur_op   = CUR_BEST;
        cmd.sw_set   = 1'b1;
      end
      S_FINISH: cmd.out_load = stat.out_free;
      default: cmd.take = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/lwts_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwts_dp: scheduler datapath
// Slot flags, ring link and stamp memories, time and block counters,
// ring walk compare and the result register.
// ----------------------------------------------------------------------------
module lwts_dp import lwts_pkg::*; #(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  lwts_in_if.sink       in_ch,
  lwts_out_if.source    out_ch,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat
);

  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam logic [TASK_SLOTS-1:0] VALID_RST = TASK_SLOTS'(1);

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [TIME_BITS-1:0] stamp_t;

  // latched request
  req_t                    req_r;
  logic [SLOT_FIELD_W-1:0] slot_r;
  logic                    rv_r;
  logic                    in_range_r;
  slot_t                   idx;

  // slot flags and scalar state
  logic [TASK_SLOTS-1:0] valid_r, ready_r, pend_r;
  stamp_t                time_r;
  slot_t                 cur_r;
  logic                  cur_valid_r;
  logic [7:0]            block_r;

  // memories; entries never written read as a self link or a zero stamp
  slot_t  next_mem  [TASK_SLOTS];
  slot_t  prev_mem  [TASK_SLOTS];
  stamp_t stamp_mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] next_init_r, prev_init_r, stamp_init_r;

  slot_t  next_rd_r, next_ra_r, prev_rd_r, prev_ra_r;
  logic   next_ok_r, prev_ok_r, stamp_ok_r;
  stamp_t stamp_rd_r;
  slot_t  next_eff, prev_eff;
  stamp_t stamp_eff;

  logic   next_we, prev_we, next_re, prev_re, stamp_we, stamp_re;
  slot_t  next_wa, next_wd, prev_wa, prev_wd, next_ra, prev_ra, stamp_wa, stamp_ra;
  slot_t  unl_addr, unl_r;

  // walk
  slot_t   walk_r, best_r;
  stamp_t  best_wait_r, wait_val;
  logic    have_r;

  // result
  status_t status_r;
  logic    sw_r;
  logic    out_valid_r;
  logic    out_sw_r;
  logic [SLOT_FIELD_W-1:0] out_sel_r;
  status_t out_status_r;
  logic    out_rdy_r;

  assign idx       = SLOT_W'(slot_r);
  assign next_eff  = next_ok_r ? next_rd_r : next_ra_r;
  assign prev_eff  = prev_ok_r ? prev_rd_r : prev_ra_r;
  assign stamp_eff = stamp_ok_r ? stamp_rd_r : '0;
  assign wait_val  = time_r - stamp_eff;
  assign unl_addr  = (cmd.unl == UNL_CUR) ? cur_r : idx;

  // take the request word
  assign in_ch.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (cmd.take && in_ch.valid) begin
      req_r      <= req_t'(in_ch.req_type);
      slot_r     <= in_ch.task_slot;
      rv_r       <= in_ch.ready_value;
      in_range_r <= (32'(in_ch.task_slot) < 32'(TASK_SLOTS));
    end
  end

  // ring write and read port selection
  always_comb begin
    next_we = 1'b0;
    next_wa = idx;
    next_wd = next_eff;
    prev_we = 1'b0;
    prev_wa = idx;
    prev_wd = '0;
    case (cmd.ring_wr)
      RW_CRT_LINK: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      RW_CRT_HEAD: begin
        next_we = 1'b1;
        next_wa = '0;
        next_wd = idx;
        prev_we = 1'b1;
        prev_wa = next_eff;
        prev_wd = idx;
      end
      RW_UNLINK: begin
        next_we = 1'b1;
        next_wa = prev_eff;
        next_wd = next_eff;
        prev_we = 1'b1;
        prev_wa = next_eff;
        prev_wd = prev_eff;
      end
      default: next_we = 1'b0;
    endcase
  end

  always_comb begin
    next_re = 1'b1;
    next_ra = unl_addr;
    if (cmd.unl == UNL_NONE) begin
      case (cmd.nrd)
        NRD_KERNEL: next_ra = '0;
        NRD_CUR:    next_ra = cur_r;
        NRD_FOLLOW: next_ra = next_eff;
        default:    next_re = 1'b0;
      endcase
    end
  end

  assign prev_re  = (cmd.unl != UNL_NONE);
  assign prev_ra  = unl_addr;
  assign stamp_re = (cmd.nrd == NRD_FOLLOW);
  assign stamp_ra = next_eff;

  always_comb begin
    stamp_we = 1'b1;
    stamp_wa = idx;
    case (cmd.stamp_wr)
      SW_KERNEL: stamp_wa = '0;
      SW_SLOT:   stamp_wa = idx;
      SW_BEST:   stamp_wa = best_r;
      default:   stamp_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) begin
      next_rd_r <= next_mem[next_ra];
      next_ok_r <= next_init_r[next_ra];
      next_ra_r <= next_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) begin
      prev_rd_r <= prev_mem[prev_ra];
      prev_ok_r <= prev_init_r[prev_ra];
      prev_ra_r <= prev_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[stamp_wa] <= time_r;
    if (stamp_re) begin
      stamp_rd_r <= stamp_mem[stamp_ra];
      stamp_ok_r <= stamp_init_r[stamp_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_init_r  <= '0;
      prev_init_r  <= '0;
      stamp_init_r <= '0;
    end else begin
      if (next_we)  next_init_r[next_wa]   <= 1'b1;
      if (prev_we)  prev_init_r[prev_wa]   <= 1'b1;
      if (stamp_we) stamp_init_r[stamp_wa] <= 1'b1;
    end
  end

  // flags, counters and current task
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= VALID_RST;
      ready_r     <= '0;
      pend_r      <= '0;
      time_r      <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      block_r     <= '0;
    end else begin
      case (cmd.flag_op)
        FL_CREATE: begin
          valid_r[idx] <= 1'b1;
          ready_r[idx] <= rv_r;
          pend_r[idx]  <= 1'b0;
        end
        FL_SET_READY: ready_r[idx] <= rv_r;
        FL_PEND:      pend_r[idx]  <= 1'b1;
        FL_FREE: begin
          valid_r[unl_r] <= 1'b0;
          ready_r[unl_r] <= 1'b0;
          pend_r[unl_r]  <= 1'b0;
        end
        default: pend_r <= pend_r;
      endcase
      case (cmd.cnt_op)
        CN_TICK:    time_r <= time_r + TIME_BITS'(1);
        CN_BLOCK:   if (block_r != BLOCK_MAX) block_r <= block_r + 8'd1;
        CN_UNBLOCK: if (block_r != 8'd0) block_r <= block_r - 8'd1;
        default:    block_r <= block_r;
      endcase
      case (cmd.cur_op)
        CUR_KERNEL: begin
          cur_r       <= '0;
          cur_valid_r <= 1'b1;
        end
        CUR_BEST: begin
          cur_r       <= best_r;
          cur_valid_r <= 1'b1;
        end
        default: cur_valid_r <= cur_valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.unl != UNL_NONE) unl_r <= unl_addr;
  end

  // ring walk: one slot a cycle, compare works on the registered link read
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      best_r      <= cur_r;
      best_wait_r <= '0;
      have_r      <= 1'b0;
    end else if (cmd.walk_cmp) begin
      if (have_r && ready_r[walk_r] && (wait_val > best_wait_r)) begin
        best_r      <= walk_r;
        best_wait_r <= wait_val;
      end
      have_r <= (cmd.nrd == NRD_FOLLOW);
    end
    if (cmd.nrd == NRD_FOLLOW) walk_r <= next_eff;
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_ch.valid) begin
      status_r <= RS_OK;
      sw_r     <= 1'b0;
    end else begin
      if (cmd.status_wr) status_r <= cmd.status;
      if (cmd.sw_set)    sw_r     <= 1'b1;
    end
  end

  // result register; hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sw_r     <= sw_r;
      out_sel_r    <= cur_valid_r ? SLOT_FIELD_W'(cur_r) : '0;
      out_status_r <= status_r;
      out_rdy_r    <= in_range_r && ready_r[idx];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.switched      = out_sw_r;
  assign out_ch.selected_slot = out_sel_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.ready_out     = out_rdy_r;

  // status toward the controller
  always_comb begin
    stat              = '0;
    stat.in_valid     = in_ch.valid;
    stat.req          = req_r;
    stat.create_ok    = in_range_r && (idx != '0) && !valid_r[idx];
    stat.delete_ok    = in_range_r && (idx != '0) && valid_r[idx];
    stat.del_is_cur   = cur_valid_r && (cur_r == idx);
    stat.set_ready_ok = in_range_r && valid_r[idx];
    stat.blocked      = (block_r != 8'd0);
    stat.cur_valid    = cur_valid_r;
    stat.kernel_ready = ready_r[0];
    stat.walk_hit     = (next_eff == cur_r);
    stat.best_is_cur  = (best_r == cur_r);
    stat.cur_pend     = pend_r[cur_r];
    stat.out_free     = !out_valid_r || out_ch.ready;
  end

endmodule
`default_nettype wire

// ===== sv/longest_wait_task_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_wait_task_scheduler: longest-waiting-first task scheduler
// Ring of task slots with the kernel task in slot 0. Yield picks the ready
// task with the oldest switch stamp; create, delete, ready, block, unblock and tick
// requests maintain the ring and counters.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake     Word
//  in_ch     in    valid/ready   req_type[2:0] task_slot[3:0] ready_value
//  out_ch    out   valid/ready   switched selected_slot[3:0] status[1:0] ready_out
//
//  One request at a time, one result word per request. A yield walks the
//  ring one link a cycle. A stall on out_ch holds the block in its finish
//  step; the next request is taken while the last result word waits.
//  Synchronous reset, no clearing pass.
//
module longest_wait_task_scheduler import lwts_pkg::*; #(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  lwts_in_if.sink    in_ch,
  lwts_out_if.source out_ch
);

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence each request: decode, ring updates, walk, stamp, deliver
  lwts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // hold slot state, memories and the result word
  lwts_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule
`default_nettype wire

// ===== sv/lwts_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwts_chk: port checks for the scheduler
// Tracks words in flight between the two channels and checks the result
// register behavior seen at the top level ports.
// ----------------------------------------------------------------------------
module lwts_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_switched,
  input logic [3:0] out_selected_slot,
  input logic [1:0] out_status,
  input logic       out_ready_out
);

  logic       in_acc, out_acc;
  logic [1:0] pending_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // count words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_switched, out_selected_slot, out_status, out_ready_out}))
    else $error("stalled result word changed");

  a_take_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second request taken while one is at work");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result word without a request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pending_r != 2'd2 && pending_r != 2'd3)
    else $error("request taken with two words in flight");

endmodule

bind longest_wait_task_scheduler lwts_chk u_lwts_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_switched      (out_ch.switched),
  .out_selected_slot (out_ch.selected_slot),
  .out_status        (out_ch.status),
  .out_ready_out     (out_ch.ready_out)
);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for longest_wait_task_scheduler
// Drives request words (tick, create, delete, set ready, yield, block,
// unblock and the unused code) through the request channel and checks every
// result word against a slot-ring tracker. Both channels idle at random, and
// the result side holds off once long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb import lwts_pkg::*; ();

  localparam int          SLOTS        = 16;
  localparam int          TIME_W       = 32;
  localparam logic [2:0]  REQ_UNUSED   = 3'd7;
  localparam int          RANDOM_WORDS = 800;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          HOLD_AT_WORD = 500;
  localparam int          DRAIN_CYCLES = 30;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic                    switched;
    logic [SLOT_FIELD_W-1:0] selected_slot;
    status_t                 status;
    logic                    ready_out;
  } sched_word_t;

  // Tracks the slot ring, stamps and counters, and holds the result words
  // still owed by the block.
  class slot_ring_tracker;
    bit                      in_use  [SLOTS];
    bit                      runnable[SLOTS];
    bit                      doomed  [SLOTS];
    logic [3:0]              fwd     [SLOTS];
    logic [3:0]              bwd     [SLOTS];
    logic [TIME_W-1:0]       stamp   [SLOTS];
    logic [TIME_W-1:0]       now;
    logic [3:0]              running;
    bit                      running_ok;
    logic [7:0]              hold_count;
    sched_word_t             owed[$];
    int                      errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        in_use[i]   = 1'b0;
        runnable[i] = 1'b0;
        doomed[i]   = 1'b0;
        fwd[i]      = 4'(i);
        bwd[i]      = 4'(i);
        stamp[i]    = '0;
      end
      in_use[0]  = 1'b1;
      now        = '0;
      running    = '0;
      running_ok = 1'b0;
      hold_count = '0;
      errors     = 0;
    endfunction

    function void unlink(logic [3:0] s);
      fwd[bwd[s]] = fwd[s];
      bwd[fwd[s]] = bwd[s];
      in_use[s]   = 1'b0;
      runnable[s] = 1'b0;
      doomed[s]   = 1'b0;
      fwd[s]      = s;
      bwd[s]      = s;
    endfunction

    // Apply one accepted request word and queue the result it owes.
    function void note_request(logic [2:0] req, logic [3:0] slot, logic rv);
      sched_word_t       w;
      logic [3:0]        cur;
      logic [3:0]        best;
      logic [3:0]        walk;
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] best_age;
      w.switched = 1'b0;
      w.status   = RS_OK;
      case (req)
        REQ_TICK: begin
          now = now + 1'b1;
        end
        REQ_CREATE: begin
          if (slot == 0 || in_use[slot]) begin
            w.status = RS_BAD_SLOT;
          end else begin
            in_use[slot]   = 1'b1;
            runnable[slot] = rv;
            doomed[slot]   = 1'b0;
            stamp[slot]    = now;
            bwd[slot]      = '0;
            fwd[slot]      = fwd[0];
            bwd[fwd[0]]    = slot;
            fwd[0]         = slot;
          end
        end
        REQ_DELETE: begin
          if (slot == 0 || !in_use[slot]) begin
            w.status = RS_BAD_SLOT;
          end else if (running_ok && running == slot) begin
            doomed[slot] = 1'b1;
          end else begin
            unlink(slot);
          end
        end
        REQ_SET_READY: begin
          if (!in_use[slot]) w.status = RS_BAD_SLOT;
          else runnable[slot] = rv;
        end
        REQ_YIELD: begin
          if (hold_count != 0) begin
            w.status = RS_BLOCKED;
          end else if (!running_ok) begin
            if (runnable[0]) begin
              stamp[0]   = now;
              running    = '0;
              running_ok = 1'b1;
              w.switched = 1'b1;
            end else begin
              w.status = RS_NO_SWITCH;
            end
          end else begin
            cur      = running;
            best     = cur;
            walk     = cur;
            best_age = '0;
            for (int k = 0; k < SLOTS; k++) begin
              walk = fwd[walk];
              if (walk == cur) break;
              if (runnable[walk]) begin
                age = now - stamp[walk];
                if (age > best_age) begin
                  best_age = age;
                  best     = walk;
                end
              end
            end
            if (best == cur) begin
              w.status = RS_NO_SWITCH;
            end else begin
              if (doomed[cur]) unlink(cur);
              stamp[best] = now;
              running     = best;
              running_ok  = 1'b1;
              w.switched  = 1'b1;
            end
          end
        end
        REQ_BLOCK: begin
          if (hold_count != BLOCK_MAX) hold_count = hold_count + 1'b1;
        end
        REQ_UNBLOCK: begin
          if (hold_count != 0) hold_count = hold_count - 1'b1;
        end
        default: begin
        end
      endcase
      w.selected_slot = running_ok ? running : '0;
      w.ready_out     = runnable[slot];
      owed.push_back(w);
    endfunction

    // Compare one accepted result word with the oldest owed word.
    function void check_result(sched_word_t got);
      sched_word_t exp_w;
      if (owed.size() == 0) begin
        $display("%0t: result word with none owed: %p", $time, got);
        errors++;
        return;
      end
      exp_w = owed.pop_front();
      if (got.switched !== exp_w.switched) begin
        $display("%0t: switched expected %0d actual %0d",
                 $time, exp_w.switched, got.switched);
        errors++;
      end
      if (got.selected_slot !== exp_w.selected_slot) begin
        $display("%0t: selected_slot expected %0d actual %0d",
                 $time, exp_w.selected_slot, got.selected_slot);
        errors++;
      end
      if (got.status !== exp_w.status) begin
        $display("%0t: status expected %0d actual %0d",
                 $time, exp_w.status, got.status);
        errors++;
      end
      if (got.ready_out !== exp_w.ready_out) begin
        $display("%0t: ready_out expected %0d actual %0d",
                 $time, exp_w.ready_out, got.ready_out);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int          tx_count    = 0;
  int          rx_count    = 0;
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;

  slot_ring_tracker ring = new();

  lwts_in_if  in_ch();
  lwts_out_if out_ch();

  longest_wait_task_scheduler uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("longest_wait_task_scheduler: mismatch");
      $finish;
    end
  end

  // Offer one request word. Gaps are drawn per word; every 64 words decide
  // whether the next stretch runs back to back. Each negedge carries at most
  // one assignment to valid, so a word that follows directly keeps valid high.
  task automatic send_word(logic [2:0] req, logic [3:0] slot, logic rv);
    int gap;
    if (tx_count % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.task_slot   <= slot;
    in_ch.ready_value <= rv;
    // Sample ready at the rising edge; the word moves when both are high.
    do @(posedge clk); while (!in_ch.ready);
    ring.note_request(req, slot, rv);
    tx_count++;
  endtask

  // Draw a random request word with weights that keep the ring busy: many
  // yields and ticks, mostly ready tasks, unblock more likely than block.
  task automatic send_random_word();
    int         pick;
    logic [2:0] req;
    pick = $urandom_range(0, 99);
    if      (pick < 22) req = REQ_TICK;
    else if (pick < 36) req = REQ_CREATE;
    else if (pick < 46) req = REQ_DELETE;
    else if (pick < 60) req = REQ_SET_READY;
    else if (pick < 85) req = REQ_YIELD;
    else if (pick < 88) req = REQ_BLOCK;
    else if (pick < 97) req = REQ_UNBLOCK;
    else                req = REQ_UNUSED;
    send_word(req, 4'($urandom_range(0, 15)), ($urandom_range(0, 3) != 0));
  endtask

  // Result side: accept words with random stalls, and once hold ready low
  // long enough for the block to fill its output register and stall input.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_count % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      stall = rx_quiet ? 0 : $urandom_range(0, 14);
      if (rx_count == HOLD_AT_WORD) stall = HOLD_CYCLES;
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      ring.check_result({out_ch.switched, out_ch.selected_slot,
                         status_t'(out_ch.status), out_ch.ready_out});
      rx_count++;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_TICK;
    in_ch.task_slot   = '0;
    in_ch.ready_value = 1'b0;
    rst_n             = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: kernel start-up, bad slots, zero-wait and tied candidates,
    // pending delete of the running task, blocking and unblock at zero.
    send_word(REQ_TICK,      4'd0,  1'b0);
    send_word(REQ_YIELD,     4'd0,  1'b0);  // kernel not ready: no switch
    send_word(REQ_SET_READY, 4'd0,  1'b1);
    send_word(REQ_YIELD,     4'd0,  1'b0);  // kernel becomes current
    send_word(REQ_YIELD,     4'd0,  1'b1);  // ring holds only the kernel
    send_word(REQ_CREATE,    4'd0,  1'b1);  // kernel slot refused
    send_word(REQ_CREATE,    4'd15, 1'b1);
    send_word(REQ_CREATE,    4'd15, 1'b0);  // already in use
    send_word(REQ_CREATE,    4'd1,  1'b1);  // same stamp as slot 15
    send_word(REQ_YIELD,     4'd1,  1'b0);  // every wait is zero
    send_word(REQ_TICK,      4'd15, 1'b1);
    send_word(REQ_YIELD,     4'd15, 1'b0);  // tie: first found wins
    send_word(REQ_DELETE,    4'd1,  1'b0);  // running: mark pending only
    send_word(REQ_DELETE,    4'd0,  1'b1);
    send_word(REQ_DELETE,    4'd7,  1'b0);  // never created
    send_word(REQ_SET_READY, 4'd7,  1'b1);
    send_word(REQ_TICK,      4'd0,  1'b0);
    send_word(REQ_YIELD,     4'd1,  1'b0);  // switch away drops slot 1
    send_word(REQ_BLOCK,     4'd0,  1'b0);
    send_word(REQ_YIELD,     4'd0,  1'b0);  // refused while blocked
    send_word(REQ_UNBLOCK,   4'd0,  1'b0);
    send_word(REQ_UNBLOCK,   4'd0,  1'b0);  // saturate at zero
    send_word(REQ_SET_READY, 4'd15, 1'b0);
    send_word(REQ_UNUSED,    4'd15, 1'b1);
    send_word(REQ_DELETE,    4'd15, 1'b1);

    // Random traffic, with one run of blocks past the counter ceiling and
    // unblocks back down past zero partway through.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3) begin
        repeat (257) send_word(REQ_BLOCK, 4'($urandom_range(0, 15)), 1'($urandom));
        send_word(REQ_YIELD, 4'd0, 1'b1);
        repeat (258) send_word(REQ_UNBLOCK, 4'($urandom_range(0, 15)), 1'($urandom));
      end
      send_random_word();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed word, then give stray words time to show.
    while (ring.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ring.errors == 0 && ring.owed.size() == 0) begin
      $display("longest_wait_task_scheduler: match");
    end else begin
      $display("longest_wait_task_scheduler: mismatch");
    end
    $finish;
  end

endmodule
